[hdl/tts_pkg.sv]
`default_nettype none
package tts_pkg;
	typedef enum logic [3:0] {
		OP_SELECT = 4'd0, OP_ALLOC = 4'd1, OP_CONSTRUCT = 4'd2, OP_STOP = 4'd3,
		OP_RESUME = 4'd4, OP_KILL = 4'd5, OP_JOIN = 4'd6, OP_SETPRIO = 4'd7,
		OP_RUN = 4'd8
	} op_t;

	localparam logic [2:0] ST_EMPTY    = 3'd0;
	localparam logic [2:0] ST_CREATED  = 3'd1;
	localparam logic [2:0] ST_READY    = 3'd2;
	localparam logic [2:0] ST_RUNNING  = 3'd3;
	localparam logic [2:0] ST_STOPPED  = 3'd4;
	localparam logic [2:0] ST_FINISHED = 3'd5;

	localparam logic [2:0] R_OK        = 3'd0;
	localparam logic [2:0] R_INVALID   = 3'd1;
	localparam logic [2:0] R_NOTAVAIL  = 3'd2;
	localparam logic [2:0] R_NOTHREADS = 3'd3;
	localparam logic [2:0] R_NOSTACKS  = 3'd4;
	localparam logic [2:0] R_BUSY      = 3'd5;
	localparam logic [2:0] R_RANGE     = 3'd6;
	localparam logic [2:0] R_WAIT      = 3'd7;

	localparam logic [7:0] NO_THREAD = 8'hFF;
	localparam logic [8:0] PRIO_NONE = 9'h1FF;

	typedef struct packed {
		logic [3:0]  operation;
		logic [7:0]  thread_index;
		logic [1:0]  core_number;
		logic [7:0]  priority_value;
		logic [7:0]  owner_process;
		logic [31:0] exit_code;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  chosen_thread;
		logic        switch_needed;
		logic [31:0] result_value;
	} res_t;

	typedef struct packed {
		logic load;
		logic scan_init;
		logic scan_step;
		logic exec;
	} tts_ctrl_t;
endpackage
`default_nettype wire

[hdl/tts_cmd_if.sv]
`default_nettype none
interface tts_cmd_if import tts_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hdl/tts_res_if.sv]
`default_nettype none
interface tts_res_if import tts_pkg::*; ();
	logic valid;
	logic ready;
	res_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hdl/thread_table_scheduler.sv]
// Channel | Direction | Payload
// cmd     | in        | operation, thread_index, core_number, priority_value,
//         |           | owner_process, exit_code
// res     | out       | status, chosen_thread, switch_needed, result_value
// After acceptance the scan examines one table entry per cycle until it has
// covered the whole table, then the execute state registers the result. The
// next command can be accepted in the cycle after the result is taken.
// Reset empties the table and frees all stacks. A stalled result holds and
// blocks the next command.
`default_nettype none
module thread_table_scheduler import tts_pkg::*; #(
	parameter int THREAD_SLOTS = 16,
	parameter int STACK_SLOTS = 16,
	parameter int CORE_COUNT = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	tts_cmd_if.sink cmd,
	tts_res_if.source res
);
	tts_ctrl_t ctrl;
	tts_ctrl #(.THREAD_SLOTS(THREAD_SLOTS)) u_ctrl (
		.clk, .arst_n, .in_valid(cmd.valid), .in_ready(cmd.ready),
		.out_valid(res.valid), .out_ready(res.ready), .ctrl
	);
	tts_dp #(.THREAD_SLOTS(THREAD_SLOTS), .STACK_SLOTS(STACK_SLOTS),
		.CORE_COUNT(CORE_COUNT)) u_dp (
		.clk, .arst_n, .ctrl, .cmd(cmd.payload), .res(res.payload)
	);
endmodule
`default_nettype wire

[hdl/tts_ctrl.sv]
`default_nettype none
module tts_ctrl import tts_pkg::*; #(
	parameter int THREAD_SLOTS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output tts_ctrl_t ctrl
);
	localparam int CW = $clog2(THREAD_SLOTS + 1);
	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC, S_OUT} state_t;
	state_t state_q;
	logic [CW-1:0] cnt_q;

	assign in_ready = (state_q == S_IDLE);
	assign ctrl.load = in_valid && in_ready;
	assign ctrl.scan_init = ctrl.load;
	assign ctrl.scan_step = (state_q == S_SCAN);
	assign ctrl.exec = (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
						cnt_q <= '0;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(THREAD_SLOTS - 1)) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[hdl/tts_dp.sv]
`default_nettype none
module tts_dp import tts_pkg::*; #(
	parameter int THREAD_SLOTS = 16,
	parameter int STACK_SLOTS = 16,
	parameter int CORE_COUNT = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire tts_ctrl_t ctrl,
	input  wire cmd_t  cmd,
	output res_t       res
);
	localparam int TW = $clog2(THREAD_SLOTS);
	localparam int SW = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
	localparam int RECIP = (65536 + THREAD_SLOTS - 1) / THREAD_SLOTS;

	logic [2:0]  st_q [THREAD_SLOTS];
	logic [7:0]  pr_q [THREAD_SLOTS];
	logic [1:0]  co_q [THREAD_SLOTS];
	logic [7:0]  pc_q [THREAD_SLOTS];
	logic [SW-1:0] sk_q [THREAD_SLOTS];
	logic        hs_q [THREAD_SLOTS];
	logic [31:0] ex_q [THREAD_SLOTS];
	logic [STACK_SLOTS-1:0] busy_q;

	cmd_t cmd_q;
	logic [TW-1:0] pos_q;
	logic [8:0] best_q;
	logic [7:0] pick_q;

	logic [TW-1:0] cur_mod, pos_next;
	logic [8:0] cur_ext;
	logic [24:0] cur_prod;
	logic [8:0] cur_quot;
	logic [15:0] cur_rem;
	logic elig;
	assign cur_ext = {1'b0, cmd.thread_index} + 9'd1;
	assign cur_prod = 25'(cur_ext) * 25'(RECIP);
	assign cur_quot = cur_prod[24:16];
	assign cur_rem = 16'(cur_ext) - 16'(cur_quot) * 16'(THREAD_SLOTS);
	assign cur_mod = TW'(cur_rem);
	assign pos_next = (pos_q == TW'(THREAD_SLOTS - 1)) ? '0 : pos_q + 1'b1;
	assign elig = (st_q[pos_q] == ST_READY || st_q[pos_q] == ST_RUNNING)
		&& co_q[pos_q] == cmd_q.core_number && {1'b0, pr_q[pos_q]} < best_q;

	logic stk_found;
	logic [SW-1:0] stk_idx;
	always_comb begin
		stk_found = 1'b0;
		stk_idx = '0;
		for (int i = STACK_SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				stk_found = 1'b1;
				stk_idx = SW'(i);
			end
		end
	end

	logic in_tab;
	logic [TW-1:0] t;
	logic [2:0] s;
	assign in_tab = {24'd0, cmd_q.thread_index} < 32'(THREAD_SLOTS);
	assign t = cmd_q.thread_index[TW-1:0];
	assign s = st_q[t];

	always_ff @(posedge clk) begin
		if (ctrl.load) cmd_q <= cmd;
		if (ctrl.scan_init) begin
			pos_q <= cur_mod;
			best_q <= PRIO_NONE;
			pick_q <= NO_THREAD;
		end else if (ctrl.scan_step) begin
			if (elig) begin
				best_q <= {1'b0, pr_q[pos_q]};
				pick_q <= 8'(pos_q);
			end
			pos_q <= pos_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < THREAD_SLOTS; i++) begin
				st_q[i] <= ST_EMPTY;
				pr_q[i] <= '0;
				co_q[i] <= '0;
				pc_q[i] <= '0;
				sk_q[i] <= '0;
				hs_q[i] <= 1'b0;
				ex_q[i] <= '0;
			end
			busy_q <= '0;
			res <= '0;
		end else if (ctrl.exec) begin
			res.status <= R_OK;
			res.chosen_thread <= NO_THREAD;
			res.switch_needed <= 1'b0;
			res.result_value <= '0;
			priority if (cmd_q.operation == OP_SELECT) begin
				res.chosen_thread <= pick_q;
				res.switch_needed <= !best_q[8] && pick_q != cmd_q.thread_index;
			end else if (cmd_q.operation == OP_ALLOC) begin
				res.status <= R_NOTHREADS;
				for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
					if (st_q[i] == ST_EMPTY) begin
						res.status <= R_OK;
						res.chosen_thread <= 8'(i);
					end
				end
				begin : alloc_wr
					logic found;
					logic [TW-1:0] k;
					found = 1'b0;
					k = '0;
					for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
						if (st_q[i] == ST_EMPTY) begin
							found = 1'b1;
							k = TW'(i);
						end
					end
					if (found) begin
						st_q[k] <= ST_CREATED;
						pr_q[k] <= cmd_q.priority_value;
						pc_q[k] <= cmd_q.owner_process;
						co_q[k] <= '0;
						ex_q[k] <= '0;
						hs_q[k] <= 1'b0;
					end
				end
			end else if (cmd_q.operation == OP_CONSTRUCT) begin
				if (!in_tab) res.status <= R_RANGE;
				else if (s != ST_CREATED) res.status <= R_BUSY;
				else if ({30'd0, cmd_q.core_number} >= 32'(CORE_COUNT))
					res.status <= R_INVALID;
				else if (!stk_found) res.status <= R_NOSTACKS;
				else begin
					busy_q[stk_idx] <= 1'b1;
					sk_q[t] <= stk_idx;
					hs_q[t] <= 1'b1;
					co_q[t] <= cmd_q.core_number;
					st_q[t] <= ST_READY;
					res.result_value <= 32'(stk_idx);
				end
			end else if (cmd_q.operation > OP_RUN || !in_tab) begin
				res.status <= R_INVALID;
			end else begin
				unique case (cmd_q.operation)
					OP_STOP: begin
						if (s == ST_READY || s == ST_RUNNING) st_q[t] <= ST_STOPPED;
						else res.status <= R_NOTAVAIL;
					end
					OP_RESUME: begin
						if (s == ST_STOPPED) st_q[t] <= ST_READY;
						else res.status <= R_NOTAVAIL;
					end
					OP_KILL: begin
						if (s != ST_EMPTY && s != ST_FINISHED) begin
							st_q[t] <= ST_FINISHED;
							ex_q[t] <= cmd_q.exit_code;
							if (hs_q[t]) busy_q[sk_q[t]] <= 1'b0;
							hs_q[t] <= 1'b0;
						end else res.status <= R_INVALID;
					end
					OP_JOIN: begin
						if (s == ST_FINISHED) begin
							res.result_value <= ex_q[t];
							st_q[t] <= ST_EMPTY;
						end else res.status <= R_WAIT;
					end
					OP_SETPRIO: pr_q[t] <= cmd_q.priority_value;
					default: begin
						if (s == ST_READY || s == ST_RUNNING) st_q[t] <= ST_RUNNING;
						else res.status <= R_NOTAVAIL;
					end
				endcase
			end
		end
	end

	logic unused;
	assign unused = ^{pc_q[0]};
endmodule
`default_nettype wire

[hdl/tts_checker.sv]
`default_nettype none
module tts_assert_checker import tts_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire res_t out_payload
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_noimm: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result dropped");
	a_sw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.switch_needed |-> out_payload.chosen_thread != NO_THREAD)
		else $error("switch without thread");
endmodule
bind thread_table_scheduler tts_assert_checker u_chk (
	.clk, .arst_n, .in_valid(cmd.valid), .in_ready(cmd.ready),
	.out_valid(res.valid), .out_ready(res.ready), .out_payload(res.payload)
);
`default_nettype wire

[bench/tts_checker.sv]
`timescale 1ns / 100ps
`default_nettype none
module tts_checker import tts_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	tts_cmd_if.sink cmd,
	tts_res_if.sink res,
	output int failures,
	output int pending,
	output int selects_seen,
	output int switches_seen
);
	localparam int THREADS = 16;
	localparam int STACKS = 16;
	localparam int CORES = 4;
	localparam logic [4:0] NO_STACK = 5'd31;

	logic [2:0] t_state [THREADS];
	logic [7:0] t_prio [THREADS];
	logic [1:0] t_core [THREADS];
	logic [7:0] t_proc [THREADS];
	logic [4:0] t_stack [THREADS];
	logic t_held [THREADS];
	logic [31:0] t_exit [THREADS];
	logic [STACKS-1:0] stack_map;
	res_t expected_results [$];

	task automatic clear_table();
		for (int i = 0; i < THREADS; i++) begin
			t_state[i] = ST_EMPTY;
			t_prio[i] = '0;
			t_core[i] = '0;
			t_proc[i] = '0;
			t_stack[i] = NO_STACK;
			t_held[i] = 1'b0;
			t_exit[i] = '0;
		end
		stack_map = '0;
	endtask

	function automatic res_t schedule_command(cmd_t c);
		res_t r;
		int t;
		logic [2:0] s;
		logic [8:0] best;
		int pos;
		r.status = R_OK;
		r.chosen_thread = NO_THREAD;
		r.switch_needed = 1'b0;
		r.result_value = '0;
		t = c.thread_index;
		if (c.operation == OP_SELECT) begin
			best = PRIO_NONE;
			pos = (t + 1) % THREADS;
			for (int n = 0; n < THREADS; n++) begin
				if ((t_state[pos] == ST_READY || t_state[pos] == ST_RUNNING) &&
				    t_core[pos] == c.core_number && {1'b0, t_prio[pos]} < best) begin
					best = {1'b0, t_prio[pos]};
					r.chosen_thread = pos[7:0];
				end
				pos = (pos + 1) % THREADS;
			end
			r.switch_needed = (best <= 9'hFF) && (r.chosen_thread != c.thread_index);
		end else if (c.operation == OP_ALLOC) begin
			r.status = R_NOTHREADS;
			for (int q = 0; q < THREADS; q++) begin
				if (r.status == R_NOTHREADS && t_state[q] == ST_EMPTY) begin
					t_state[q] = ST_CREATED;
					t_prio[q] = c.priority_value;
					t_proc[q] = c.owner_process;
					t_core[q] = '0;
					t_exit[q] = '0;
					t_stack[q] = NO_STACK;
					t_held[q] = 1'b0;
					r.chosen_thread = q[7:0];
					r.status = R_OK;
				end
			end
		end else if (c.operation == OP_CONSTRUCT) begin
			if (t >= THREADS) r.status = R_RANGE;
			else if (t_state[t] != ST_CREATED) r.status = R_BUSY;
			else if (c.core_number >= CORES) r.status = R_INVALID;
			else begin
				r.status = R_NOSTACKS;
				for (int q = 0; q < STACKS; q++) begin
					if (r.status == R_NOSTACKS && !stack_map[q]) begin
						stack_map[q] = 1'b1;
						t_stack[t] = q[4:0];
						t_held[t] = 1'b1;
						t_core[t] = c.core_number;
						t_state[t] = ST_READY;
						r.result_value = q;
						r.status = R_OK;
					end
				end
			end
		end else if (c.operation > OP_RUN || t >= THREADS) begin
			r.status = R_INVALID;
		end else begin
			s = t_state[t];
			case (c.operation)
				OP_STOP: begin
					if (s == ST_READY || s == ST_RUNNING) t_state[t] = ST_STOPPED;
					else r.status = R_NOTAVAIL;
				end
				OP_RESUME: begin
					if (s == ST_STOPPED) t_state[t] = ST_READY;
					else r.status = R_NOTAVAIL;
				end
				OP_KILL: begin
					if (s != ST_EMPTY && s != ST_FINISHED) begin
						t_state[t] = ST_FINISHED;
						t_exit[t] = c.exit_code;
						if (t_held[t] && t_stack[t] < STACKS) stack_map[t_stack[t]] = 1'b0;
						t_stack[t] = NO_STACK;
						t_held[t] = 1'b0;
					end else r.status = R_INVALID;
				end
				OP_JOIN: begin
					if (s == ST_FINISHED) begin
						r.result_value = t_exit[t];
						t_state[t] = ST_EMPTY;
					end else r.status = R_WAIT;
				end
				OP_SETPRIO: t_prio[t] = c.priority_value;
				default: begin
					if (s == ST_READY || s == ST_RUNNING) t_state[t] = ST_RUNNING;
					else r.status = R_NOTAVAIL;
				end
			endcase
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		failures++;
	endtask

	initial begin
		failures = 0;
		clear_table();
	end

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			clear_table();
			expected_results.delete();
		end else begin
			if (cmd.valid && cmd.ready) begin
				if (cmd.payload.operation == OP_SELECT) selects_seen++;
				expected_results.push_back(schedule_command(cmd.payload));
			end
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", res.payload.result_value, 32'd0);
				end else begin
					e = expected_results.pop_front();
					if (res.payload.switch_needed) switches_seen++;
					if (res.payload.status !== e.status)
						report_mismatch("status", 32'(res.payload.status), 32'(e.status));
					if (res.payload.chosen_thread !== e.chosen_thread)
						report_mismatch("chosen_thread", 32'(res.payload.chosen_thread),
							32'(e.chosen_thread));
					if (res.payload.switch_needed !== e.switch_needed)
						report_mismatch("switch_needed", 32'(res.payload.switch_needed),
							32'(e.switch_needed));
					if (res.payload.result_value !== e.result_value)
						report_mismatch("result_value", res.payload.result_value,
							e.result_value);
				end
			end
		end
		pending = expected_results.size();
	end

	initial begin
		selects_seen = 0;
		switches_seen = 0;
		pending = 0;
	end
endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import tts_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int failures;
	int pending;
	int selects_seen;
	int switches_seen;
	int idle_cycles = 0;
	int sent = 0;

	tts_cmd_if cmd_ch ();
	tts_res_if res_ch ();

	thread_table_scheduler u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch.sink),
		.res(res_ch.source)
	);

	tts_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch.sink),
		.res(res_ch.sink),
		.failures(failures),
		.pending(pending),
		.selects_seen(selects_seen),
		.switches_seen(switches_seen)
	);

	always #10 clk = ~clk;

	function automatic int gap_length();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 93) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	function automatic cmd_t random_command(bit well_formed);
		cmd_t c;
		int p;
		c.operation = 4'($urandom_range(0, 15));
		c.thread_index = 8'($urandom);
		c.core_number = 2'($urandom);
		c.priority_value = 8'($urandom);
		c.owner_process = 8'($urandom);
		c.exit_code = $urandom;
		if (well_formed) begin
			p = $urandom_range(0, 99);
			if (p < 25) c.operation = OP_SELECT;
			else if (p < 37) c.operation = OP_ALLOC;
			else if (p < 52) c.operation = OP_CONSTRUCT;
			else c.operation = 4'($urandom_range(3, 8));
			if ($urandom_range(0, 9) != 0) c.thread_index = 8'($urandom_range(0, 15));
			else if (c.operation == OP_SELECT) c.thread_index = NO_THREAD;
			if ($urandom_range(0, 1)) c.priority_value = 8'($urandom_range(0, 3));
		end
		return c;
	endfunction

	task automatic send_command(cmd_t c);
		int n;
		n = gap_length();
		if (n != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		cmd_ch.payload <= c;
		cmd_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic directed(logic [3:0] op, logic [7:0] t, logic [1:0] core,
		logic [7:0] prio, logic [31:0] code);
		cmd_t c;
		c.operation = op;
		c.thread_index = t;
		c.core_number = core;
		c.priority_value = prio;
		c.owner_process = ~prio;
		c.exit_code = code;
		send_command(c);
	endtask

	initial begin
		int n;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			n = gap_length();
			if (n != 0) begin
				res_ch.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 30) - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.payload = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		directed(OP_SELECT, NO_THREAD, 2'd0, 8'd0, 32'd0);
		directed(OP_ALLOC, 8'd0, 2'd0, 8'd255, 32'd0);
		directed(OP_ALLOC, 8'd0, 2'd0, 8'd0, 32'd0);
		directed(OP_CONSTRUCT, 8'd0, 2'd3, 8'd0, 32'd0);
		directed(OP_CONSTRUCT, 8'd1, 2'd3, 8'd0, 32'd0);
		directed(OP_CONSTRUCT, 8'd1, 2'd3, 8'd0, 32'd0);
		directed(OP_CONSTRUCT, 8'd200, 2'd0, 8'd0, 32'd0);
		directed(OP_SELECT, 8'd0, 2'd3, 8'd0, 32'd0);
		directed(OP_SELECT, 8'd1, 2'd3, 8'd0, 32'd0);
		directed(OP_RUN, 8'd1, 2'd0, 8'd0, 32'd0);
		directed(OP_STOP, 8'd1, 2'd0, 8'd0, 32'd0);
		directed(OP_STOP, 8'd1, 2'd0, 8'd0, 32'd0);
		directed(OP_RESUME, 8'd1, 2'd0, 8'd0, 32'd0);
		directed(OP_SETPRIO, 8'd15, 2'd0, 8'd255, 32'd0);
		directed(OP_JOIN, 8'd0, 2'd0, 8'd0, 32'd0);
		directed(OP_KILL, 8'd0, 2'd0, 8'd0, 32'h8000_0000);
		directed(OP_KILL, 8'd0, 2'd0, 8'd0, 32'd0);
		directed(OP_JOIN, 8'd0, 2'd0, 8'd0, 32'd0);
		directed(OP_KILL, 8'd1, 2'd0, 8'd0, 32'h7FFF_FFFF);
		directed(OP_JOIN, 8'd1, 2'd0, 8'd0, 32'd0);
		directed(OP_RUN, 8'd255, 2'd0, 8'd0, 32'd0);
		directed(4'd15, 8'd3, 2'd0, 8'd0, 32'd0);
		directed(4'd9, 8'd3, 2'd0, 8'd0, 32'd0);
		for (int i = 0; i < 18; i++) directed(OP_ALLOC, 8'd0, 2'd0, 8'(i), 32'd0);
		for (int i = 0; i < 16; i++) directed(OP_CONSTRUCT, 8'(i), 2'(i), 8'd0, 32'd0);
		drain();
		for (int i = 0; i < 1700; i++) begin
			send_command(random_command($urandom_range(0, 9) != 0));
			if (i == 850) drain();
		end
		drain();
		repeat (40) @(negedge clk);
		$display("Sent %0d commands, %0d of them selects; %0d results asked for a switch.",
			sent, selects_seen, switches_seen);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
